FILE: design/ahsl_pkg.sv
// ----------------------------------------------------------------------------
// ahsl_pkg
// Types and constants shared by the averaged hysteresis sensor LED block.
// ----------------------------------------------------------------------------
`default_nettype none

package ahsl_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int SUM_W       = 13;
   localparam int COUNT_W     = 3;
   localparam int CSR_INDEX_W = 3;

   // group queue between accumulator and evaluator
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // exact reciprocal division of a group sum: floor(sum * RECIP / 2**DIV_SHIFT)
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = 21;
   localparam int PROD_W    = SUM_W + RECIP_W;

   // light compare width: 11 * 1023 fits in 14 bits
   localparam int SCALED_W = 14;

   localparam logic [SAMPLE_W-1:0] TEMP_ON_RESET       = 10'd226;
   localparam logic [SAMPLE_W-1:0] TEMP_OFF_RESET      = 10'd220;
   localparam logic [SAMPLE_W-1:0] TOUCH_PRESS_RESET   = 10'd300;
   localparam logic [SAMPLE_W-1:0] TOUCH_RELEASE_RESET = 10'd1012;
   localparam logic [SAMPLE_W-1:0] TOUCH_DEAD_RESET    = 10'd700;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_ON_LEVEL       = 3'd0,
      CSR_TEMP_OFF_LEVEL      = 3'd1,
      CSR_TOUCH_PRESS_LEVEL   = 3'd2,
      CSR_TOUCH_RELEASE_LEVEL = 3'd3,
      CSR_TOUCH_DEAD_LOW      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] light_sample;
      logic [SAMPLE_W-1:0] touch_sample;
      logic [SAMPLE_W-1:0] temp_sample;
   } req_type;

   typedef struct packed {
      logic                light_led;
      logic                temp_led;
      logic                touch_led;
      logic [SAMPLE_W-1:0] light_avg;
      logic [SAMPLE_W-1:0] touch_avg;
      logic [SAMPLE_W-1:0] temp_avg;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] light_sum;
      logic [SUM_W-1:0] touch_sum;
      logic [SUM_W-1:0] temp_sum;
   } sums_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] light_avg;
      logic [SAMPLE_W-1:0] touch_avg;
      logic [SAMPLE_W-1:0] temp_avg;
   } avgs_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] temp_on_level;
      logic [SAMPLE_W-1:0] temp_off_level;
      logic [SAMPLE_W-1:0] touch_press_level;
      logic [SAMPLE_W-1:0] touch_release_level;
      logic [SAMPLE_W-1:0] touch_dead_low;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/averaged_hysteresis_sensor_leds.sv
// ----------------------------------------------------------------------------
// averaged_hysteresis_sensor_leds
// Group averaging of light, touch and temperature samples driving three
// LEDs through hysteresis comparators.
//
// req_*: one sample set per transfer, taken every cycle while req_ready is
//    high; req_ready drops only when the four-entry group queue is full.
// rsp_*: one result per finished group of SAMPLES_PER_AVG sets, except the
//    first group after reset, which only sets the light baseline.
// csr_*: register writes (temperature and touch levels), always ready.
// Throughput: one sample set per cycle while req_ready is high; the
//    reciprocal divider and the comparator stage each take one group per
//    cycle while the receiver does not stall. A group's sums pass the queue,
//    the divide stage register and the output register, in that order.
// Receiver stall: the result holds in the output register; the divide stage
//    holds one more group, the queue keeps absorbing groups and req_ready
//    falls only once the queue fills.
// Reset: sums, count, baseline, LED states, toggle arm and queue clear; the
//    level registers return to 226, 220, 300, 1012 and 700.
// ----------------------------------------------------------------------------
`default_nettype none

module averaged_hysteresis_sensor_leds #(
   parameter int SAMPLES_PER_AVG = 5
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire ahsl_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output ahsl_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ahsl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ahsl_pkg::SAMPLE_W-1:0]        csr_wdata
);

   ahsl_pkg::cfg_type       cfg_ff, cfg_in;
   ahsl_pkg::sums_type      queue_wdata, queue_rdata;
   logic                    queue_push, queue_pop, queue_valid, queue_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (ahsl_pkg::csr_index_type'(csr_index))
            ahsl_pkg::CSR_TEMP_ON_LEVEL:       cfg_in.temp_on_level       = csr_wdata;
            ahsl_pkg::CSR_TEMP_OFF_LEVEL:      cfg_in.temp_off_level      = csr_wdata;
            ahsl_pkg::CSR_TOUCH_PRESS_LEVEL:   cfg_in.touch_press_level   = csr_wdata;
            ahsl_pkg::CSR_TOUCH_RELEASE_LEVEL: cfg_in.touch_release_level = csr_wdata;
            ahsl_pkg::CSR_TOUCH_DEAD_LOW:      cfg_in.touch_dead_low      = csr_wdata;
            default: begin
               // drop writes to unmapped indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_on_level       <= ahsl_pkg::TEMP_ON_RESET;
         cfg_ff.temp_off_level      <= ahsl_pkg::TEMP_OFF_RESET;
         cfg_ff.touch_press_level   <= ahsl_pkg::TOUCH_PRESS_RESET;
         cfg_ff.touch_release_level <= ahsl_pkg::TOUCH_RELEASE_RESET;
         cfg_ff.touch_dead_low      <= ahsl_pkg::TOUCH_DEAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ahsl_front #(
      .SAMPLES_PER_AVG (SAMPLES_PER_AVG)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_wdata (queue_wdata)
   );

   ahsl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (queue_push),
      .wdata  (queue_wdata),
      .full   (queue_full),
      .pop    (queue_pop),
      .rvalid (queue_valid),
      .rdata  (queue_rdata)
   );

   ahsl_back #(
      .SAMPLES_PER_AVG (SAMPLES_PER_AVG)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_valid (queue_valid),
      .queue_rdata (queue_rdata),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/ahsl_front.sv
// ----------------------------------------------------------------------------
// ahsl_front
// Accepts sample sets, sums each channel and pushes the sums of every
// finished group into the group queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsl_front #(
   parameter int SAMPLES_PER_AVG = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ahsl_pkg::req_type  req_data,
   input  wire logic               queue_full,
   output logic                    queue_push,
   output ahsl_pkg::sums_type      queue_wdata
);

   localparam logic [ahsl_pkg::COUNT_W-1:0] GROUP_END =
      ahsl_pkg::COUNT_W'(SAMPLES_PER_AVG);

   ahsl_pkg::sums_type                 sums_ff, sums_in, sums_next;
   logic [ahsl_pkg::COUNT_W-1:0]       count_ff, count_in, count_next;
   logic                               accept, group_done;

   always_comb begin
      accept    = req_valid && req_ready;
      sums_next.light_sum = sums_ff.light_sum
                          + ahsl_pkg::SUM_W'(req_data.light_sample);
      sums_next.touch_sum = sums_ff.touch_sum
                          + ahsl_pkg::SUM_W'(req_data.touch_sample);
      sums_next.temp_sum  = sums_ff.temp_sum
                          + ahsl_pkg::SUM_W'(req_data.temp_sample);
      count_next = count_ff + 1'b1;
      group_done = (count_next == GROUP_END);

      sums_in  = sums_ff;
      count_in = count_ff;
      if (accept) begin
         // restart the sums once the group is handed off
         sums_in  = group_done ? '0 : sums_next;
         count_in = group_done ? '0 : count_next;
      end
   end

   assign req_ready   = !queue_full;
   assign queue_push  = accept && group_done;
   assign queue_wdata = sums_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff  <= '0;
         count_ff <= '0;
      end else begin
         sums_ff  <= sums_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ahsl_queue.sv
// ----------------------------------------------------------------------------
// ahsl_queue
// Short queue of finished group sums between accumulator and evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsl_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ahsl_pkg::sums_type    wdata,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       rvalid,
   output ahsl_pkg::sums_type         rdata
);

   localparam logic [ahsl_pkg::QUEUE_PTR_W:0] DEPTH =
      (ahsl_pkg::QUEUE_PTR_W + 1)'(ahsl_pkg::QUEUE_DEPTH);

   ahsl_pkg::sums_type                  mem [ahsl_pkg::QUEUE_DEPTH];
   logic [ahsl_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ahsl_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ahsl_pkg::QUEUE_PTR_W:0]      fill_ff, fill_in;
   logic                                do_push, do_pop;

   always_comb begin
      do_push   = push && (fill_ff != DEPTH);
      do_pop    = pop && (fill_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   assign full   = (fill_ff == DEPTH);
   assign rvalid = (fill_ff != '0);
   assign rdata  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ahsl_back.sv
// ----------------------------------------------------------------------------
// ahsl_back
// Takes finished group sums, divides them into averages, applies the
// baseline and hysteresis rules and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module ahsl_back #(
   parameter int SAMPLES_PER_AVG = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ahsl_pkg::cfg_type   cfg,
   input  wire logic                queue_valid,
   input  wire ahsl_pkg::sums_type  queue_rdata,
   output logic                     queue_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ahsl_pkg::rsp_type        rsp_data
);

   localparam logic [ahsl_pkg::RECIP_W-1:0] RECIP = ahsl_pkg::RECIP_W'(
      ((1 << ahsl_pkg::DIV_SHIFT) + SAMPLES_PER_AVG - 1) / SAMPLES_PER_AVG);

   localparam int SW = ahsl_pkg::SCALED_W;

   // stage 1: averages
   logic                                s1_valid_ff, s1_valid_in;
   ahsl_pkg::avgs_type                  s1_avg_ff, s1_avg_in;
   logic [ahsl_pkg::PROD_W-1:0]         light_prod, touch_prod, temp_prod;

   // LED state
   logic                                base_taken_ff, base_taken_in;
   logic [ahsl_pkg::SAMPLE_W-1:0]       base_ff, base_in;
   logic                                light_on_ff, light_on_in;
   logic                                temp_on_ff, temp_on_in;
   logic                                touch_on_ff, touch_on_in;
   logic                                armed_ff, armed_in;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   ahsl_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                                s1_retire, emit;
   logic [SW-1:0]                       light_scaled, base_hi, base_lo;
   logic                                light_set, light_clr, temp_set, temp_clr;
   logic                                touch_dead, touch_release, touch_press;
   logic                                armed_mid;

   always_comb begin
      light_prod = ahsl_pkg::PROD_W'(queue_rdata.light_sum) * ahsl_pkg::PROD_W'(RECIP);
      touch_prod = ahsl_pkg::PROD_W'(queue_rdata.touch_sum) * ahsl_pkg::PROD_W'(RECIP);
      temp_prod  = ahsl_pkg::PROD_W'(queue_rdata.temp_sum) * ahsl_pkg::PROD_W'(RECIP);
      s1_avg_in.light_avg = light_prod[ahsl_pkg::DIV_SHIFT +: ahsl_pkg::SAMPLE_W];
      s1_avg_in.touch_avg = touch_prod[ahsl_pkg::DIV_SHIFT +: ahsl_pkg::SAMPLE_W];
      s1_avg_in.temp_avg  = temp_prod[ahsl_pkg::DIV_SHIFT +: ahsl_pkg::SAMPLE_W];
   end

   always_comb begin
      // a baseline group never needs the output register
      s1_retire = s1_valid_ff && (!base_taken_ff || !rsp_valid_ff || rsp_ready);
      emit      = s1_retire && base_taken_ff;
      queue_pop = queue_valid && (!s1_valid_ff || s1_retire);

      if (queue_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_retire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // light: 10*avg against 11*base and 9*base
      light_scaled = (SW'(s1_avg_ff.light_avg) << 3) + (SW'(s1_avg_ff.light_avg) << 1);
      base_hi      = (SW'(base_ff) << 3) + (SW'(base_ff) << 1) + SW'(base_ff);
      base_lo      = (SW'(base_ff) << 3) + SW'(base_ff);
      light_set    = (light_scaled >= base_hi);
      light_clr    = (light_scaled <= base_lo);

      temp_set = (s1_avg_ff.temp_avg >= cfg.temp_on_level);
      temp_clr = (s1_avg_ff.temp_avg <= cfg.temp_off_level);

      touch_dead    = (s1_avg_ff.touch_avg > cfg.touch_dead_low)
                   && (s1_avg_ff.touch_avg < cfg.touch_release_level);
      touch_release = (s1_avg_ff.touch_avg >= cfg.touch_release_level);
      touch_press   = (s1_avg_ff.touch_avg <= cfg.touch_press_level);
      armed_mid     = armed_ff || touch_release;

      base_taken_in = base_taken_ff;
      base_in       = base_ff;
      light_on_in   = light_on_ff;
      temp_on_in    = temp_on_ff;
      touch_on_in   = touch_on_ff;
      armed_in      = armed_ff;

      if (s1_retire && !base_taken_ff) begin
         base_taken_in = 1'b1;
         base_in       = s1_avg_ff.light_avg;
      end

      if (emit) begin
         // off wins where both thresholds hold
         light_on_in = light_clr ? 1'b0 : (light_set ? 1'b1 : light_on_ff);
         temp_on_in  = temp_clr ? 1'b0 : (temp_set ? 1'b1 : temp_on_ff);
         if (!touch_dead) begin
            armed_in = armed_mid;
            if (touch_press && armed_mid) begin
               armed_in    = 1'b0;
               touch_on_in = !touch_on_ff;
            end
         end
      end

      rsp_in.light_led = light_on_in;
      rsp_in.temp_led  = temp_on_in;
      rsp_in.touch_led = touch_on_in;
      rsp_in.light_avg = s1_avg_ff.light_avg;
      rsp_in.touch_avg = s1_avg_ff.touch_avg;
      rsp_in.temp_avg  = s1_avg_ff.temp_avg;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_avg_ff <= s1_avg_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         base_taken_ff <= 1'b0;
         base_ff       <= '0;
         light_on_ff   <= 1'b0;
         temp_on_ff    <= 1'b0;
         touch_on_ff   <= 1'b0;
         armed_ff      <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         base_taken_ff <= base_taken_in;
         base_ff       <= base_in;
         light_on_ff   <= light_on_in;
         temp_on_ff    <= temp_on_in;
         touch_on_ff   <= touch_on_in;
         armed_ff      <= armed_in;
      end
   end

endmodule

`default_nettype wire
